// ----- sv/fixed_partition_fit_allocator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// fixed partition fit allocator assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_UNIT_DEFINES_SVH

// condition holds in every cycle out of reset
`define FPFA_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("fpfa assertion failed");

// antecedent in one cycle implies consequent in the next
`define FPFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fpfa assertion failed");

`endif

// ----- sv/fpfa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpfa_pkg
// types and codes shared by the fixed partition fit allocator
// ----------------------------------------------------------------------------
package fpfa_pkg;

    localparam int SLOT_W    = 4;
    localparam int FSIZE_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int BLOCK_W   = 4;
    localparam int REM_W     = 16;
    localparam int TDATA_W   = 24;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int MODE_W    = 2;
    localparam int COUNT_W   = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 1'b1;

    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_REQ  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_LOADED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PLACED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic rd_en;
        logic wr_back;
        logic load_res;
    } t_ctl_cmd;

    typedef struct packed {
        logic last;
        logic cnt_zero;
        logic out_free;
    } t_ctl_status;

endpackage

// ----- sv/fpfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpfa_ctrl
// sequencer for load, table scan, write back and result hand-off
// ----------------------------------------------------------------------------
`include "fixed_partition_fit_allocator_unit_defines.svh"

module fpfa_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tuser,
    output logic                 o_s_tready,
    input  fpfa_pkg::t_ctl_status i_status,
    output fpfa_pkg::t_ctl_cmd   o_cmd
);

    fpfa_pkg::t_state r_state;
    fpfa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpfa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            fpfa_pkg::S_IDLE: begin
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd.start = 1'b1;
                    if (i_s_tuser == fpfa_pkg::CMD_REQ && !i_status.cnt_zero) begin
                        n_state = fpfa_pkg::S_SCAN;
                    end else begin
                        n_state = fpfa_pkg::S_DONE;
                    end
                end
            end
            fpfa_pkg::S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_status.last) begin
                    n_state = fpfa_pkg::S_DRAIN;
                end
            end
            fpfa_pkg::S_DRAIN: begin
                n_state = fpfa_pkg::S_WRITE;
            end
            fpfa_pkg::S_WRITE: begin
                o_cmd.wr_back = 1'b1;
                n_state       = fpfa_pkg::S_DONE;
            end
            fpfa_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_res = 1'b1;
                    n_state        = fpfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fpfa_pkg::S_IDLE;
            end
        endcase
    end

    `FPFA_ASSERT_NEXT(a_accept_leaves_idle, i_s_tvalid && o_s_tready, r_state != fpfa_pkg::S_IDLE)
    `FPFA_ASSERT_NEXT(a_scan_ends_in_drain, r_state == fpfa_pkg::S_SCAN && i_status.last,
                      r_state == fpfa_pkg::S_DRAIN)
    `FPFA_ASSERT_NEXT(a_done_waits, r_state == fpfa_pkg::S_DONE && !i_status.out_free,
                      r_state == fpfa_pkg::S_DONE)

endmodule

// ----- sv/fpfa_dpath.sv -----
// ----------------------------------------------------------------------------
// fpfa_dpath
// partition table, config registers, fit compare and output register
// ----------------------------------------------------------------------------
`include "fixed_partition_fit_allocator_unit_defines.svh"

module fpfa_dpath #(
    parameter int PARTITIONS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [fpfa_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic [fpfa_pkg::TDATA_W-1:0]         i_s_tdata,
    input  logic                                 i_s_tuser,
    input  logic                                 i_m_tready,
    output logic                                 o_m_tvalid,
    output logic [fpfa_pkg::TDATA_W-1:0]         o_m_tdata,
    output logic [fpfa_pkg::STATUS_W-1:0]        o_m_tuser,
    input  fpfa_pkg::t_ctl_cmd                   i_cmd,
    output fpfa_pkg::t_ctl_status                o_status
);

    localparam int AW  = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CLG = $clog2(PARTITIONS + 1);
    localparam int CW  = (CLG > fpfa_pkg::COUNT_W) ? CLG : fpfa_pkg::COUNT_W;
    localparam int SW  = SIZE_BITS;

    logic [SW-1:0]                   r_mem [PARTITIONS];
    logic [SW-1:0]                   r_rd_data;
    logic [fpfa_pkg::MODE_W-1:0]     r_fit_mode;
    logic [fpfa_pkg::COUNT_W-1:0]    r_part_count;
    logic [AW-1:0]                   r_addr;
    logic                            r_rd_vld;
    logic [AW-1:0]                   r_rd_idx;
    logic                            r_cmd_kind;
    logic [fpfa_pkg::SLOT_W-1:0]     r_slot;
    logic                            r_slot_ok;
    logic [SW-1:0]                   r_size;
    logic                            r_found;
    logic [AW-1:0]                   r_pick;
    logic [SW-1:0]                   r_pick_left;
    logic                            r_o_valid;
    logic [fpfa_pkg::STATUS_W-1:0]   r_o_status;
    logic [fpfa_pkg::BLOCK_W-1:0]    r_o_block;
    logic [fpfa_pkg::REM_W-1:0]      r_o_rem;

    logic [fpfa_pkg::SLOT_W-1:0]     w_in_slot;
    logic [SW-1:0]                   w_in_size;
    logic                            w_in_slot_ok;
    logic [CW-1:0]                   w_cnt_cfg;
    logic [CW-1:0]                   w_cnt;
    logic                            w_fits;
    logic [SW-1:0]                   w_left;
    logic                            w_take;
    logic                            w_we;
    logic [AW-1:0]                   w_wa;
    logic [SW-1:0]                   w_wd;

    assign w_in_slot    = i_s_tdata[fpfa_pkg::SLOT_W-1:0];
    assign w_in_size    = SW'(i_s_tdata[fpfa_pkg::SLOT_W +: fpfa_pkg::FSIZE_W]);
    assign w_in_slot_ok = CW'(w_in_slot) < CW'(PARTITIONS);

    assign w_cnt_cfg = CW'(r_part_count);
    assign w_cnt     = (w_cnt_cfg > CW'(PARTITIONS)) ? CW'(PARTITIONS) : w_cnt_cfg;

    assign o_status.last     = (CW'(r_addr) + CW'(1)) == w_cnt;
    assign o_status.cnt_zero = w_cnt == '0;
    assign o_status.out_free = !r_o_valid || i_m_tready;

    // fit compare on the word read out last cycle
    assign w_fits = r_rd_data >= r_size;
    assign w_left = r_rd_data - r_size;
    always_comb begin
        w_take = 1'b0;
        if (r_rd_vld && w_fits) begin
            if (!r_found) begin
                w_take = 1'b1;
            end else begin
                case (r_fit_mode)
                    fpfa_pkg::FIT_BEST:  w_take = w_left < r_pick_left;
                    fpfa_pkg::FIT_WORST: w_take = w_left > r_pick_left;
                    default:             w_take = 1'b0;
                endcase
            end
        end
    end

    // single write port: load at accept, or write back of the chosen entry
    always_comb begin
        w_we = 1'b0;
        w_wa = r_pick;
        w_wd = r_pick_left;
        if (i_cmd.start && i_s_tuser == fpfa_pkg::CMD_LOAD && w_in_slot_ok) begin
            w_we = 1'b1;
            w_wa = AW'(w_in_slot);
            w_wd = w_in_size;
        end else if (i_cmd.wr_back && r_found) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode   <= fpfa_pkg::FIT_FIRST;
            r_part_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fpfa_pkg::CFG_FIT_MODE:   r_fit_mode   <= i_cfg_data[fpfa_pkg::MODE_W-1:0];
                fpfa_pkg::CFG_PART_COUNT: r_part_count <= i_cfg_data;
                default:                  r_part_count <= r_part_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
            r_addr    <= '0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.start) begin
                r_addr  <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.rd_en) begin
                    r_addr <= r_addr + AW'(1);
                end
                if (w_take) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.load_res) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cmd_kind <= i_s_tuser;
            r_slot     <= w_in_slot;
            r_slot_ok  <= w_in_slot_ok;
            r_size     <= w_in_size;
        end
        if (i_cmd.rd_en) begin
            r_rd_idx <= r_addr;
        end
        if (w_take) begin
            r_pick      <= r_rd_idx;
            r_pick_left <= w_left;
        end
        if (i_cmd.load_res) begin
            if (r_cmd_kind == fpfa_pkg::CMD_LOAD) begin
                r_o_status <= fpfa_pkg::ST_LOADED;
                r_o_block  <= r_slot;
                r_o_rem    <= r_slot_ok ? fpfa_pkg::REM_W'(r_size) : '0;
            end else if (r_found) begin
                r_o_status <= fpfa_pkg::ST_PLACED;
                r_o_block  <= fpfa_pkg::BLOCK_W'(r_pick);
                r_o_rem    <= fpfa_pkg::REM_W'(r_pick_left);
            end else begin
                r_o_status <= fpfa_pkg::ST_NOFIT;
                r_o_block  <= '0;
                r_o_rem    <= '0;
            end
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tuser  = r_o_status;
    assign o_m_tdata  = {{(fpfa_pkg::TDATA_W - fpfa_pkg::REM_W - fpfa_pkg::BLOCK_W){1'b0}},
                         r_o_rem, r_o_block};

    `FPFA_ASSERT_NEXT(a_read_follows_enable, i_cmd.rd_en, r_rd_vld)
    `FPFA_ASSERT_ALWAYS(a_no_start_on_write_back, !(i_cmd.start && i_cmd.wr_back))
    `FPFA_ASSERT_ALWAYS(a_result_into_free_reg, !i_cmd.load_res || !r_o_valid || i_m_tready)

endmodule

// ----- sv/fixed_partition_fit_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_unit
// Keeps a table of free sizes for PARTITIONS fixed partitions and places
// requests by first, best or worst fit, lower index winning ties. A load
// request writes its slot at accept and goes straight to result hand-off.
// An allocation request scans the table through its single read port, one
// slot per cycle over min(partition_count, PARTITIONS) slots, then does the
// last compare, writes back the chosen entry and hands off the result, which
// waits for a free output register. One request is in work at a time; the
// next is accepted once the previous result has moved to the output register.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_unit #(
    parameter int PARTITIONS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fpfa_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [fpfa_pkg::TDATA_W-1:0]       i_s_tdata,   // slot[3:0], size[19:4]
    input  logic                               i_s_tuser,   // cmd[0]
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [fpfa_pkg::TDATA_W-1:0]       o_m_tdata,   // block[3:0], remaining[19:4]
    output logic [fpfa_pkg::STATUS_W-1:0]      o_m_tuser    // status[1:0]
);

    fpfa_pkg::t_ctl_cmd    w_cmd;
    fpfa_pkg::t_ctl_status w_status;

    fpfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    fpfa_dpath #(
        .PARTITIONS (PARTITIONS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cmd      (w_cmd),
        .o_status   (w_status)
    );

endmodule

// ----- bench/fit_result_checker.sv -----
// ----------------------------------------------------------------------------
// fit result checker
// Watches the configuration port and both stream channels of the partition
// fit allocator. It keeps its own copy of the partition free-size table and of
// the fit policy, works out the result of each accepted request, and compares
// each result leaving the block, field by field, with the oldest one owed.
// ----------------------------------------------------------------------------
module fit_result_checker #(
    parameter int PARTITIONS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fpfa_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [fpfa_pkg::TDATA_W-1:0]   i_s_tdata,   // slot[3:0], size[19:4]
    input  logic                           i_s_tuser,   // cmd[0]
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [fpfa_pkg::TDATA_W-1:0]   i_m_tdata,   // block[3:0], remaining[19:4]
    input  logic [fpfa_pkg::STATUS_W-1:0]  i_m_tuser,   // status[1:0]
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_loaded,
    output int                             o_placed,
    output int                             o_rejected
);

    typedef struct packed {
        logic [fpfa_pkg::STATUS_W-1:0] status;
        logic [fpfa_pkg::BLOCK_W-1:0]  block;
        logic [fpfa_pkg::REM_W-1:0]    remaining;
    } t_fit_result;

    logic [fpfa_pkg::FSIZE_W-1:0] free_size [PARTITIONS];
    logic [fpfa_pkg::MODE_W-1:0]  fit_policy;
    logic [fpfa_pkg::COUNT_W-1:0] part_count;
    t_fit_result                  owed_results [$];
    int                           n_owed;
    int                           n_seen;
    int                           fail_count;
    int                           n_loaded;
    int                           n_placed;
    int                           n_rejected;

    assign o_fail_count = fail_count;
    assign o_pending    = n_owed - n_seen;
    assign o_loaded     = n_loaded;
    assign o_placed     = n_placed;
    assign o_rejected   = n_rejected;

    initial begin
        fail_count = 0;
        n_loaded   = 0;
        n_placed   = 0;
        n_rejected = 0;
        n_owed     = 0;
        n_seen     = 0;
        fit_policy = fpfa_pkg::FIT_FIRST;
        part_count = '0;
    end

    function automatic t_fit_result apply_item(input logic cmd,
                                               input logic [fpfa_pkg::SLOT_W-1:0] slot,
                                               input logic [fpfa_pkg::FSIZE_W-1:0] size);
        t_fit_result                  r;
        int                           span;
        bit                           found;
        bit                           take;
        int                           pick;
        logic [fpfa_pkg::FSIZE_W-1:0] pick_left;
        logic [fpfa_pkg::FSIZE_W-1:0] left;
        r         = '0;
        found     = 1'b0;
        pick      = 0;
        pick_left = '0;
        span      = (part_count > PARTITIONS) ? PARTITIONS : int'(part_count);
        if (cmd == fpfa_pkg::CMD_LOAD) begin
            if (slot < PARTITIONS) begin
                free_size[slot] = size;
                r.remaining     = size;
            end
            r.status = fpfa_pkg::ST_LOADED;
            r.block  = slot;
            return r;
        end
        for (int j = 0; j < span; j++) begin
            if (free_size[j] >= size) begin
                left = free_size[j] - size;
                if (!found)
                    take = 1'b1;
                else if (fit_policy == fpfa_pkg::FIT_BEST)
                    take = left < pick_left;
                else if (fit_policy == fpfa_pkg::FIT_WORST)
                    take = left > pick_left;
                else
                    take = 1'b0;
                if (take) begin
                    found     = 1'b1;
                    pick      = j;
                    pick_left = left;
                end
            end
        end
        if (found) begin
            free_size[pick] = pick_left;
            r.status        = fpfa_pkg::ST_PLACED;
            r.block         = pick[fpfa_pkg::BLOCK_W-1:0];
            r.remaining     = pick_left;
        end else begin
            r.status = fpfa_pkg::ST_NOFIT;
        end
        return r;
    endfunction

    task automatic note_miss(input string what, input int want, input int got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at %0t: %s expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_fit_result want;
        t_fit_result got;
        if (!i_rst_n) begin
            fit_policy = fpfa_pkg::FIT_FIRST;
            part_count = '0;
            owed_results.delete();
            n_owed <= 0;
            n_seen <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == fpfa_pkg::CFG_FIT_MODE)
                    fit_policy = i_cfg_data[fpfa_pkg::MODE_W-1:0];
                else if (i_cfg_idx == fpfa_pkg::CFG_PART_COUNT)
                    part_count = i_cfg_data[fpfa_pkg::COUNT_W-1:0];
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status    = i_m_tuser;
                got.block     = i_m_tdata[fpfa_pkg::BLOCK_W-1:0];
                got.remaining = i_m_tdata[fpfa_pkg::BLOCK_W +: fpfa_pkg::REM_W];
                n_seen <= n_seen + 1;
                if (owed_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result at %0t with no request owed: status %0d block %0d",
                                 $time, got.status, got.block);
                end else begin
                    want = owed_results.pop_front();
                    if (got.status != want.status)
                        note_miss("status", want.status, got.status);
                    if (got.block != want.block)
                        note_miss("block", want.block, got.block);
                    if (got.remaining != want.remaining)
                        note_miss("remaining", want.remaining, got.remaining);
                    case (want.status)
                        fpfa_pkg::ST_LOADED: n_loaded++;
                        fpfa_pkg::ST_PLACED: n_placed++;
                        default:             n_rejected++;
                    endcase
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                owed_results.push_back(apply_item(i_s_tuser,
                                                  i_s_tdata[fpfa_pkg::SLOT_W-1:0],
                                                  i_s_tdata[fpfa_pkg::SLOT_W +:
                                                            fpfa_pkg::FSIZE_W]));
                n_owed <= n_owed + 1;
            end
        end
    end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// partition fit allocator testbench
// Loads the partition table, then walks first, best, worst and undefined fit
// policies over a range of partition counts with directed and random requests.
// Both stream sides idle at random; the receiver also holds off once for a
// long stretch. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PARTITIONS    = 16;
    localparam int PHASES        = 11;
    localparam int PHASE_ITEMS   = 100;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 300000;
    localparam logic [fpfa_pkg::MODE_W-1:0] FIT_UNDEF = 2'd3;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           cfg_we   = 1'b0;
    logic [fpfa_pkg::CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [fpfa_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [fpfa_pkg::TDATA_W-1:0]   s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [fpfa_pkg::TDATA_W-1:0]   m_tdata;
    logic [fpfa_pkg::STATUS_W-1:0]  m_tuser;

    int fail_count;
    int pending;
    int n_loaded;
    int n_placed;
    int n_rejected;
    int idle_pct    = 36;
    int cycles      = 0;
    int items_sent  = 0;
    int policies    = 0;
    logic hold_armed = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left  = 0;

    always #5 clk = ~clk;

    fixed_partition_fit_allocator_unit #(
        .PARTITIONS(PARTITIONS),
        .SIZE_BITS (16)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser)
    );

    fit_result_checker #(.PARTITIONS(PARTITIONS)) watch (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_loaded    (n_loaded),
        .o_placed    (n_placed),
        .o_rejected  (n_rejected)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_armed && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic send_item(input logic cmd, input logic [fpfa_pkg::SLOT_W-1:0] slot,
                             input logic [fpfa_pkg::FSIZE_W-1:0] size);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(fpfa_pkg::TDATA_W - fpfa_pkg::SLOT_W - fpfa_pkg::FSIZE_W){1'b0}},
                     size, slot};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    task automatic apply_policy(input logic [fpfa_pkg::MODE_W-1:0] mode,
                                input logic [fpfa_pkg::COUNT_W-1:0] count);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= fpfa_pkg::CFG_FIT_MODE;
        cfg_data <= fpfa_pkg::CFG_W'(mode);
        @(posedge clk);
        cfg_idx  <= fpfa_pkg::CFG_PART_COUNT;
        cfg_data <= count;
        @(posedge clk);
        cfg_we   <= 1'b0;
        policies++;
    endtask

    function automatic logic [fpfa_pkg::FSIZE_W-1:0] pick_size();
        case ($urandom_range(9))
            0, 1, 2, 3: return fpfa_pkg::FSIZE_W'($urandom_range(255));
            4, 5, 6:    return fpfa_pkg::FSIZE_W'($urandom_range(4095));
            7, 8:       return fpfa_pkg::FSIZE_W'($urandom());
            default:    return $urandom_range(1) ? '1 : '0;
        endcase
    endfunction

    initial begin
        logic [fpfa_pkg::FSIZE_W-1:0] table_sizes [PARTITIONS];
        logic [fpfa_pkg::MODE_W-1:0]  phase_modes [PHASES];
        logic [fpfa_pkg::COUNT_W-1:0] phase_counts [PHASES];
        table_sizes  = '{16'hFFFF, 16'd0, 16'd100, 16'd300, 16'd100, 16'd200, 16'd5000,
                         16'd2000, 16'd100, 16'd1, 16'hFFFE, 16'd300, 16'd50, 16'd2000,
                         16'd7, 16'd150};
        phase_modes  = '{fpfa_pkg::FIT_FIRST, fpfa_pkg::FIT_BEST, fpfa_pkg::FIT_WORST,
                         FIT_UNDEF, fpfa_pkg::FIT_BEST, fpfa_pkg::FIT_WORST,
                         fpfa_pkg::FIT_FIRST, fpfa_pkg::FIT_BEST, fpfa_pkg::FIT_WORST,
                         FIT_UNDEF, fpfa_pkg::FIT_BEST};
        phase_counts = '{5'd16, 5'd0, 5'd5, 5'd31, 5'd1, 5'd16, 5'd12, 5'd17, 5'd16,
                         5'd8, 5'd16};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no partitions in use after reset
        send_item(fpfa_pkg::CMD_REQ, 4'd0, 16'd5);
        for (int i = 0; i < PARTITIONS; i++)
            send_item(fpfa_pkg::CMD_LOAD, fpfa_pkg::SLOT_W'(i), table_sizes[i]);
        apply_policy(fpfa_pkg::FIT_FIRST, 5'd16);
        send_item(fpfa_pkg::CMD_REQ, 4'hF, 16'd0);
        send_item(fpfa_pkg::CMD_REQ, 4'd0, 16'hFFFF);
        apply_policy(fpfa_pkg::FIT_BEST, 5'd31);
        send_item(fpfa_pkg::CMD_REQ, 4'd3, 16'd100);
        send_item(fpfa_pkg::CMD_REQ, 4'd9, 16'd100);
        apply_policy(fpfa_pkg::FIT_WORST, 5'd16);
        send_item(fpfa_pkg::CMD_REQ, 4'd0, 16'd2000);
        apply_policy(FIT_UNDEF, 5'd16);
        send_item(fpfa_pkg::CMD_REQ, 4'd0, 16'd150);
        apply_policy(fpfa_pkg::FIT_BEST, 5'd1);
        send_item(fpfa_pkg::CMD_REQ, 4'd0, 16'd1);

        for (int ph = 0; ph < PHASES; ph++) begin
            apply_policy(phase_modes[ph], phase_counts[ph]);
            if (ph == 5)
                idle_pct <= 0;
            else if (ph == 6)
                idle_pct <= 36;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 2 && k == 10)
                    hold_armed <= 1'b1;
                if ($urandom_range(99) < 30)
                    send_item(fpfa_pkg::CMD_LOAD, fpfa_pkg::SLOT_W'($urandom_range(15)),
                              pick_size());
                else
                    send_item(fpfa_pkg::CMD_REQ, fpfa_pkg::SLOT_W'($urandom()),
                              pick_size());
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d requests under %0d fit policy settings", items_sent, policies);
        $display("results: %0d loads, %0d placed, %0d not placed",
                 n_loaded, n_placed, n_rejected);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
